@@ sv/ssa_pkg.sv @@
package ssa_pkg;

    // table size and derived widths
    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LIM_W     = ($clog2(NUM_SLOTS + 1) > 7) ? $clog2(NUM_SLOTS + 1) : 7;

    // field widths
    localparam int SIZE_W  = 7;
    localparam int IDX_W   = 7;
    localparam int GIVEN_W = 6;
    localparam int OPS_W   = 32;

    localparam logic [SIZE_W-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FREE  = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_SIZE     = 3'd1,
        ST_OVER_BUDGET  = 3'd2,
        ST_NO_FREE_SLOT = 3'd3,
        ST_BAD_SLOT     = 3'd4,
        ST_NOT_IN_USE   = 3'd5,
        ST_BUFFER_SMALL = 3'd6
    } status_t;

    // one request word
    typedef struct packed {
        logic [1:0]        req_type;
        logic [SIZE_W-1:0] alloc_size;
        logic [IDX_W-1:0]  slot;
        logic [SIZE_W-1:0] buffer_size;
    } item_t;

    // one result word
    typedef struct packed {
        logic [2:0]         status;
        logic [GIVEN_W-1:0] slot_given;
        logic [SIZE_W-1:0]  stored_size;
        logic [SIZE_W-1:0]  available;
        logic [OPS_W-1:0]   op_total;
    } result_t;

    // first free slot search result
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } free_t;

endpackage

@@ sv/ssa_ram.sv @@
module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ssa_first_free.sv @@
module ssa_first_free import ssa_pkg::*; (
    input  logic [NUM_SLOTS-1:0] busy,
    input  logic [LIM_W-1:0]     limit,
    output free_t                free
);

    // lowest clear busy bit below the usable limit
    always_comb begin
        free = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!busy[i] && (LIM_W'(i) < limit)) begin
                free.found = 1'b1;
                free.idx   = SLOT_W'(i);
            end
        end
    end

endmodule

@@ sv/ssa_exec.sv @@
module ssa_exec import ssa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              exec_en,
    input  item_t             item,
    input  logic [IDX_W-1:0]  rd_slot,
    output result_t           result
);

    logic [SIZE_W-1:0]    capacity_reg;
    logic [NUM_SLOTS-1:0] busy_reg, busy_next;
    logic [SIZE_W-1:0]    used_reg, used_next;
    logic [OPS_W-1:0]     ops_reg, ops_next;
    logic                 fwd_hit_reg, fwd_hit_next;
    logic [SIZE_W-1:0]    fwd_data_reg;

    logic [LIM_W-1:0]  limit;
    free_t             free;
    logic              wr_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] idx;
    logic [SIZE_W-1:0] ram_q;
    logic [SIZE_W-1:0] slot_len;
    logic [SIZE_W:0]   sum;
    logic              idx_bad;
    status_t           status;
    logic [GIVEN_W-1:0] given;
    logic [SIZE_W-1:0] stored;

    // usable slot limit
    always_comb begin
        if (LIM_W'(capacity_reg) < LIM_W'(NUM_SLOTS)) begin
            limit = LIM_W'(capacity_reg);
        end else begin
            limit = LIM_W'(NUM_SLOTS);
        end
    end

    ssa_first_free u_first_free (
        .busy  (busy_reg),
        .limit (limit),
        .free  (free)
    );

    // stored sizes, with write-to-read forwarding
    assign rd_addr      = SLOT_W'(rd_slot);
    assign fwd_hit_next = wr_en && (free.idx == rd_addr);

    ssa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (NUM_SLOTS)
    ) u_len_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (free.idx),
        .wr_data (item.alloc_size),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign slot_len = fwd_hit_reg ? fwd_data_reg : ram_q;
    assign idx      = SLOT_W'(item.slot);
    assign sum      = {1'b0, used_reg} + {1'b0, item.alloc_size};
    assign idx_bad  = (LIM_W'(item.slot) >= limit);

    // request decode and state update
    always_comb begin
        busy_next = busy_reg;
        used_next = used_reg;
        ops_next  = ops_reg;
        status    = ST_OK;
        given     = '0;
        stored    = '0;
        wr_en     = 1'b0;
        case (item.req_type)
            REQ_ALLOC: begin
                if (item.alloc_size == '0) begin
                    status = ST_BAD_SIZE;
                end else if (sum > {1'b0, capacity_reg}) begin
                    status = ST_OVER_BUDGET;
                end else if (!free.found) begin
                    status = ST_NO_FREE_SLOT;
                end else begin
                    wr_en               = exec_en;
                    busy_next[free.idx] = 1'b1;
                    used_next           = sum[SIZE_W-1:0];
                    ops_next            = ops_reg + 1'b1;
                    given               = GIVEN_W'(free.idx);
                end
            end
            REQ_READ, REQ_FREE: begin
                if (idx_bad) begin
                    status = ST_BAD_SLOT;
                end else if (!busy_reg[idx]) begin
                    status = ST_NOT_IN_USE;
                end else if (item.req_type == REQ_READ) begin
                    if (item.buffer_size < slot_len) begin
                        status = ST_BUFFER_SMALL;
                    end else begin
                        stored   = slot_len;
                        ops_next = ops_reg + 1'b1;
                    end
                end else begin
                    busy_next[idx] = 1'b0;
                    used_next      = (used_reg >= slot_len) ? used_reg - slot_len : '0;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // result word
    always_comb begin
        result.status      = status;
        result.slot_given  = given;
        result.stored_size = stored;
        result.available   = (capacity_reg > used_next) ? capacity_reg - used_next : '0;
        result.op_total    = ops_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            busy_reg     <= '0;
            used_reg     <= '0;
            ops_reg      <= '0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (exec_en) begin
                busy_reg <= busy_next;
                used_reg <= used_next;
                ops_reg  <= ops_next;
            end
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    // forwarded size
    always_ff @(posedge aclk) begin
        fwd_data_reg <= item.alloc_size;
    end

endmodule

@@ sv/swap_slot_allocator.sv @@
// swap_slot_allocator: first-fit slot allocator with a shared size budget
// path: a word accepted into the input register moves on to the result register, which drives m_valid
// throughput: one word per cycle while m_ready is high; the slot search, budget add
// and size table read all finish between the input register and the result register
// reset (aresetn, synchronous, active low): all slots free, used total and
// operation count zero, capacity 64; stored sizes are not cleared
module swap_slot_allocator import ssa_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [SIZE_W-1:0]   cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [SIZE_W-1:0]   s_alloc_size,
    input  logic [IDX_W-1:0]    s_slot,
    input  logic [SIZE_W-1:0]   s_buffer_size,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [GIVEN_W-1:0]  m_slot_given,
    output logic [SIZE_W-1:0]   m_stored_size,
    output logic [SIZE_W-1:0]   m_available,
    output logic [OPS_W-1:0]    m_op_total
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic             advance;
    logic             s_fire;
    logic [IDX_W-1:0] rd_slot;
    result_t          result;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    // size table read address follows the word entering the input register
    assign rd_slot = s_fire ? s_slot : in_item_reg.slot;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.req_type    <= s_req_type;
            in_item_reg.alloc_size  <= s_alloc_size;
            in_item_reg.slot        <= s_slot;
            in_item_reg.buffer_size <= s_buffer_size;
        end
    end

    ssa_exec u_exec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .exec_en     (advance),
        .item        (in_item_reg),
        .rd_slot     (rd_slot),
        .result      (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_res_reg.status;
    assign m_slot_given  = out_res_reg.slot_given;
    assign m_stored_size = out_res_reg.stored_size;
    assign m_available   = out_res_reg.available;
    assign m_op_total    = out_res_reg.op_total;

endmodule
